FILE: src/mbht_pkg.sv
// ----------------------------------------------------------------------------
// mbht_pkg
// Shared types, constants and the bucket fold of the blocked-MAC hash table.
// ----------------------------------------------------------------------------
package mbht_pkg;

    localparam int MAC_W    = 48;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int BUCKET_W = 6;
    localparam int FOLD_W   = 18;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    // Fold the six bytes, most significant byte first: x = (x << 2) ^ byte, then x ^= x >> 8.
    function automatic logic [FOLD_W-1:0] hash_fold(input logic [MAC_W-1:0] mac);
        logic [FOLD_W-1:0] x;
        x = '0;
        for (int k = 5; k >= 0; k--)
        begin
            x = {x[FOLD_W-3:0], 2'b00} ^ {10'b0, mac[8*k +: 8]};
        end
        return x ^ (x >> 8);
    endfunction

endpackage

FILE: src/mbht_req_if.sv
// ----------------------------------------------------------------------------
// mbht_req_if
// Request channel: operation and MAC address with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mbht_req_if import mbht_pkg::*; ();
    logic             valid;
    logic             ready;
    op_t              operation;
    logic [MAC_W-1:0] mac;

    modport source (output valid, output operation, output mac, input ready);
    modport sink   (input valid, input operation, input mac, output ready);
endinterface

FILE: src/mbht_rsp_if.sv
// ----------------------------------------------------------------------------
// mbht_rsp_if
// Response channel: found flag, status code and bucket index.
// ----------------------------------------------------------------------------
interface mbht_rsp_if import mbht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    status_t             status;
    logic [BUCKET_W-1:0] bucket;

    modport source (output valid, output found, output status, output bucket,
                    input ready);
    modport sink   (input valid, input found, input status, input bucket,
                    output ready);
endinterface

FILE: src/mac_block_hash_table.sv
// ----------------------------------------------------------------------------
// mac_block_hash_table
// Hashed table of blocked MAC addresses: lookup, add, delete and flush.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item (operation, mac); it is taken when valid and ready
//   are high at a rising edge. rsp returns exactly one item per request:
//   found, status and the 6-bit bucket index.
//   ready is high only while the sequencer is idle. A lookup, add or delete
//   reads the WAYS entries of the bucket from the MAC RAM one per cycle through
//   its single read port and compares each in the following cycle, so no new
//   item is accepted until its scan and decision are done. A flush clears
//   all valid flops at once when the flush item is accepted.
//   The result sits in an output register; a new item is accepted while it
//   waits, and the sequencer holds in its final state until the register
//   is free, so a stalled receiver backs up no further than that.
//   Reset empties the table (all valid flops clear) and drops any result;
//   MAC storage is not cleared and is only compared under its valid bit.
// ----------------------------------------------------------------------------
module mac_block_hash_table import mbht_pkg::*; #(
    parameter int BUCKETS = 64,
    parameter int WAYS    = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    mbht_req_if.sink  req,
    mbht_rsp_if.source rsp
);
    localparam int ENTRIES = BUCKETS * WAYS;
    localparam int AW      = $clog2(ENTRIES);
    localparam int BW      = $clog2(BUCKETS);
    localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW      = $clog2(WAYS + 1);
    localparam logic [BW-1:0] BKT_MASK = BW'(BUCKETS - 1);
    localparam logic [WW-1:0] LAST_WAY = WW'(WAYS - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(WAYS);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [ENTRIES-1:0] valid_reg;
    op_t               op_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [BW-1:0]     bucket_reg;
    logic [AW-1:0]     base_reg;
    logic [CW-1:0]     issue_cnt_reg;
    logic              cmp_vld_reg;
    logic [WW-1:0]     cmp_way_reg;
    logic              hit_reg, free_reg;
    logic [WW-1:0]     hit_way_reg, free_way_reg;

    logic              rsp_valid_reg;
    logic              found_reg;
    status_t           status_reg;
    logic [BUCKET_W-1:0] rsp_bucket_reg;

    logic              req_fire;
    logic [FOLD_W-1:0] fold;
    logic [BW-1:0]     req_bucket;
    logic [AW-1:0]     rd_addr, cmp_addr, wr_addr, clr_addr;
    logic [MAC_W-1:0]  rd_data;
    logic              issuing, last_cmp, entry_vld, entry_hit;
    logic              out_free, dec_fire, tbl_we, tbl_clr;
    status_t           status_next;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign fold       = hash_fold(req.mac);
    assign req_bucket = fold[BW-1:0] & BKT_MASK;

    assign issuing   = (state_reg == S_SCAN) && (issue_cnt_reg != CNT_END);
    assign rd_addr   = base_reg + AW'(issue_cnt_reg[WW-1:0]);
    assign cmp_addr  = base_reg + AW'(cmp_way_reg);
    assign wr_addr   = base_reg + AW'(free_way_reg);
    assign clr_addr  = base_reg + AW'(hit_way_reg);
    assign entry_vld = valid_reg[cmp_addr];
    assign entry_hit = entry_vld && (rd_data == mac_reg);
    assign last_cmp  = (state_reg == S_SCAN) && cmp_vld_reg && (cmp_way_reg == LAST_WAY);

    assign out_free = !rsp_valid_reg || rsp.ready;
    assign dec_fire = (state_reg == S_DECIDE) && out_free;
    assign tbl_we   = dec_fire && (op_reg == OP_ADD) && !hit_reg && free_reg;
    assign tbl_clr  = dec_fire && (op_reg == OP_DELETE) && hit_reg;

    mbht_ram #(
        .WIDTH (MAC_W),
        .DEPTH (ENTRIES)
    ) u_mac_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (wr_addr),
        .wdata (mac_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        case (op_reg)
            OP_LOOKUP: status_next = hit_reg ? ST_DONE : ST_ABSENT;
            OP_ADD:    status_next = hit_reg ? ST_PRESENT : (free_reg ? ST_DONE : ST_FULL);
            OP_DELETE: status_next = hit_reg ? ST_DONE : ST_ABSENT;
            default:   status_next = ST_DONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.operation == OP_FLUSH) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            issue_cnt_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_fire && (req.operation == OP_FLUSH))
            begin
                valid_reg <= '0;
            end
            else if (tbl_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            else if (tbl_clr)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end

            if (req_fire)
            begin
                issue_cnt_reg <= '0;
            end
            else if (issuing)
            begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end
            cmp_vld_reg <= issuing;

            if (dec_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and scan bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg   <= req.operation;
            mac_reg  <= req.mac;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
            if (req.operation == OP_FLUSH)
            begin
                bucket_reg <= '0;
                base_reg   <= '0;
            end
            else
            begin
                bucket_reg <= req_bucket;
                base_reg   <= AW'(req_bucket) * AW'(WAYS);
            end
        end
        cmp_way_reg <= issue_cnt_reg[WW-1:0];
        if ((state_reg == S_SCAN) && cmp_vld_reg)
        begin
            if (entry_hit && !hit_reg)
            begin
                hit_reg     <= 1'b1;
                hit_way_reg <= cmp_way_reg;
            end
            else if (!entry_vld && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_way_reg <= cmp_way_reg;
            end
        end
        if (dec_fire)
        begin
            found_reg      <= hit_reg;
            status_reg     <= status_next;
            rsp_bucket_reg <= BUCKET_W'(bucket_reg);
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;
    assign rsp.bucket = rsp_bucket_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issue_cnt_reg <= CNT_END))
        else $error("way issue counter ran past the bucket");

    a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> !valid_reg[wr_addr])
        else $error("add would overwrite a valid entry");

    a_del_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_clr |-> valid_reg[clr_addr])
        else $error("delete targets an entry that is not valid");

    a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.operation == OP_FLUSH)) |=> (valid_reg == '0))
        else $error("flush left valid entries");

    a_hit_free_apart: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && hit_reg && free_reg) |-> (hit_way_reg != free_way_reg))
        else $error("hit way and free way coincide");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        dec_fire |=> (rsp_valid_reg && (state_reg == S_IDLE)))
        else $error("result not presented after decide");
endmodule

FILE: src/mbht_ram.sv
// ----------------------------------------------------------------------------
// mbht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbht_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: bench/mac_block_hash_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_block_hash_table_test
// Drives lookup, add, delete and flush items with random gaps and receiver
// stalls. It predicts found, status and bucket from its own copy of the table
// and checks every response in order.
// ----------------------------------------------------------------------------
module mac_block_hash_table_test;
    import mbht_pkg::*;

    localparam int NUM_BUCKETS = 64;
    localparam int NUM_WAYS    = 4;
    localparam int NUM_SLOTS   = NUM_BUCKETS * NUM_WAYS;
    localparam int RANDOM_ITEMS = 1100;
    localparam int POOL_SIZE   = 24;
    localparam int HOT_BUCKETS = 5;
    localparam int MAX_PRINTS  = 100;

    typedef struct packed {
        logic                found;
        status_t             status;
        logic [BUCKET_W-1:0] bucket;
    } table_reply_t;

    class mac_table_scoreboard;
        bit           slot_valid [NUM_SLOTS];
        logic [47:0]  slot_mac   [NUM_SLOTS];
        table_reply_t expected_replies [$];

        static function int unsigned fold_bucket(logic [47:0] mac);
            int unsigned x;
            x = 0;
            for (int k = 5; k >= 0; k--)
            begin
                x = (x << 2) ^ int'(mac[8*k +: 8]);
            end
            x = x ^ (x >> 8);
            return x & (NUM_BUCKETS - 1);
        endfunction

        function void note_request(op_t op, logic [47:0] mac);
            table_reply_t reply;
            int unsigned  b;
            int           hit_slot;
            int           free_slot;
            int           idx;
            hit_slot  = -1;
            free_slot = -1;
            reply     = '0;
            if (op == OP_FLUSH)
            begin
                foreach (slot_valid[i])
                    slot_valid[i] = 1'b0;
                reply.status = ST_DONE;
                expected_replies.push_back(reply);
                return;
            end
            b = fold_bucket(mac);
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                idx = b * NUM_WAYS + w;
                if (slot_valid[idx])
                begin
                    if (hit_slot < 0 && slot_mac[idx] == mac)
                        hit_slot = idx;
                end
                else if (free_slot < 0)
                    free_slot = idx;
            end
            reply.found  = (hit_slot >= 0);
            reply.bucket = b[BUCKET_W-1:0];
            case (op)
                OP_LOOKUP: reply.status = reply.found ? ST_DONE : ST_ABSENT;
                OP_ADD:
                begin
                    if (reply.found)
                        reply.status = ST_PRESENT;
                    else if (free_slot < 0)
                        reply.status = ST_FULL;
                    else
                    begin
                        slot_valid[free_slot] = 1'b1;
                        slot_mac[free_slot]   = mac;
                        reply.status = ST_DONE;
                    end
                end
                default:
                begin
                    if (reply.found)
                    begin
                        slot_valid[hit_slot] = 1'b0;
                        reply.status = ST_DONE;
                    end
                    else
                        reply.status = ST_ABSENT;
                end
            endcase
            expected_replies.push_back(reply);
        endfunction

        // Empty string when the reply matches the oldest expectation.
        function string check_result(logic found, status_t status,
                                     logic [BUCKET_W-1:0] bucket);
            table_reply_t want;
            string        msg;
            if (expected_replies.size() == 0)
                return $sformatf("unexpected reply found=%0d status=%s bucket=%0d",
                                 found, status.name(), bucket);
            want = expected_replies.pop_front();
            msg  = "";
            if (found !== want.found)
                msg = {msg, $sformatf(" found %0d want %0d", found, want.found)};
            if (status !== want.status)
                msg = {msg, $sformatf(" status %s want %s", status.name(),
                                      want.status.name())};
            if (bucket !== want.bucket)
                msg = {msg, $sformatf(" bucket %0d want %0d", bucket, want.bucket)};
            if (msg.len() != 0)
                msg = {"reply mismatch:", msg};
            return msg;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mbht_req_if req_bus ();
    mbht_rsp_if rsp_bus ();

    mac_block_hash_table #(
        .BUCKETS (NUM_BUCKETS),
        .WAYS    (NUM_WAYS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    mac_table_scoreboard sb = new();

    int          errors;
    bit          calm;
    int          stall_left;
    string       check_msg;
    logic [47:0] mac_pool [POOL_SIZE];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    task automatic report(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] random_mac();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    function automatic logic [47:0] mac_in_bucket(int unsigned b);
        logic [47:0] m;
        m = random_mac();
        while (mac_table_scoreboard::fold_bucket(m) != b)
            m = random_mac();
        return m;
    endfunction

    // Crowd a few buckets so that full buckets and hits are common.
    function automatic void build_pool();
        int unsigned hot [HOT_BUCKETS];
        foreach (hot[j])
            hot[j] = $urandom_range(0, NUM_BUCKETS - 1);
        foreach (mac_pool[i])
            mac_pool[i] = mac_in_bucket(hot[i % HOT_BUCKETS]);
    endfunction

    task automatic send_item(op_t op, logic [47:0] mac);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op;
        req_bus.mac       <= mac;
        do
            @(posedge clk);
        while (!req_bus.ready);
        sb.note_request(op, mac);
    endtask

    // Response side: check accepted items, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            check_msg = sb.check_result(rsp_bus.found, rsp_bus.status,
                                        rsp_bus.bucket);
            if (check_msg.len() != 0)
                report(check_msg);
        end
        if (stall_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    initial
    begin
        #2000000;
        $display("mac_block_hash_table test failed");
        $finish;
    end

    initial
    begin
        logic [47:0] same_bucket [5];
        logic [47:0] m;
        op_t         op;
        int          r;
        int unsigned b;

        errors     = 0;
        calm       = 1'b0;
        stall_left = 0;
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.operation <= OP_LOOKUP;
        req_bus.mac       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, extremes of the MAC, hit and miss paths.
        send_item(OP_LOOKUP, 48'h0);
        send_item(OP_ADD, 48'h0);
        send_item(OP_ADD, 48'h0);
        send_item(OP_LOOKUP, 48'h0);
        send_item(OP_ADD, '1);
        send_item(OP_LOOKUP, '1);
        send_item(OP_DELETE, '1);
        send_item(OP_DELETE, '1);
        send_item(OP_LOOKUP, '1);

        // Five MACs in one bucket: the fifth add overflows the ways.
        b = $urandom_range(0, NUM_BUCKETS - 1);
        foreach (same_bucket[i])
            same_bucket[i] = mac_in_bucket(b);
        foreach (same_bucket[i])
            send_item(OP_ADD, same_bucket[i]);
        send_item(OP_LOOKUP, same_bucket[4]);
        send_item(OP_DELETE, same_bucket[1]);
        send_item(OP_ADD, same_bucket[4]);
        send_item(OP_LOOKUP, same_bucket[1]);
        send_item(OP_LOOKUP, same_bucket[4]);
        send_item(OP_FLUSH, random_mac());
        send_item(OP_LOOKUP, 48'h0);
        send_item(OP_DELETE, same_bucket[0]);
        send_item(OP_ADD, same_bucket[3]);
        send_item(OP_LOOKUP, same_bucket[3]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = ((i / 80) % 4 == 3);
            if (i % 150 == 0)
                build_pool();
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_FLUSH;
            else if (r < 45)
                op = OP_ADD;
            else if (r < 70)
                op = OP_LOOKUP;
            else
                op = OP_DELETE;
            if (op == OP_FLUSH || $urandom_range(0, 99) < 12)
                m = random_mac();
            else
                m = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_item(op, m);
        end
        req_bus.valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            report($sformatf("%0d replies never arrived", sb.pending()));

        if (errors == 0)
            $display("mac_block_hash_table test passed");
        else
            $display("mac_block_hash_table test failed");
        $finish;
    end

endmodule

FILE: sim.f
src/mbht_pkg.sv
src/mbht_req_if.sv
src/mbht_rsp_if.sv
src/mbht_ram.sv
src/mac_block_hash_table.sv
bench/mac_block_hash_table_test.sv
